### src/scsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scsa_pkg;

    localparam int SCSA_MAX_ROWS      = 4096;
    localparam int SCSA_MAX_COLUMNS   = 4096;
    localparam int SCSA_MAX_NONZEROS  = 65536;

    localparam int ROWS_W   = 13;
    localparam int SCORE_W  = 40;
    localparam int WEIGHT_W = 32;
    localparam int ROW_W    = 12;
    localparam int PTR_W    = 17;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd4096;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    localparam logic [1:0] KIND_LOAD_PTR = 2'd0;
    localparam logic [1:0] KIND_LOAD_NZ  = 2'd1;
    localparam logic [1:0] KIND_ADD_COL  = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [12:0]                pointer_slot;
        logic [PTR_W-1:0]           pointer_value;
        logic [15:0]                entry_slot;
        logic [ROW_W-1:0]           entry_row;
        logic signed [WEIGHT_W-1:0] entry_weight;
        logic [ROW_W-1:0]           word_column;
        logic                       first_word;
        logic [ROW_W-1:0]           read_row;
    } t_in_item;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      score_valid;
        logic                      saturated;
    } t_out_item;

endpackage

`default_nettype wire

### src/scsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scsa_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/sparse_column_score_accumulator_unit.sv
// Loads pass ST_EXEC and ST_DONE; a read of a row in use adds ST_RDATA between them.
// Add-column items pass ST_CLR over the active rows when first_word clears scores, then
// ST_COL, ST_PTR0, ST_PTR1, then ST_SCRD and ST_ACC per nonzero whose row is in use and
// ST_SCRD alone per skipped nonzero. One item at a time: the next transfer can be taken
// in the cycle after the result registers; the score port does one read-modify-write.
// Synchronous active-low reset clears control, the saturation flag and sets
// rows_in_use to 4096; memory contents are not initialized.
`timescale 1ns / 1ps
`default_nettype none

module sparse_column_score_accumulator_unit
    import scsa_pkg::*;
#(
    parameter int MAX_ROWS     = SCSA_MAX_ROWS,
    parameter int MAX_COLUMNS  = SCSA_MAX_COLUMNS,
    parameter int MAX_NONZEROS = SCSA_MAX_NONZEROS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ROWS_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data
);

    localparam int COL_DEPTH = MAX_COLUMNS + 1;
    localparam int COL_AW    = $clog2(COL_DEPTH);
    localparam int NZ_AW     = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NZ_W      = ROW_W + WEIGHT_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EXEC  = 4'd1;
    localparam logic [3:0] ST_CLR   = 4'd2;
    localparam logic [3:0] ST_COL   = 4'd3;
    localparam logic [3:0] ST_PTR0  = 4'd4;
    localparam logic [3:0] ST_PTR1  = 4'd5;
    localparam logic [3:0] ST_SCRD  = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_RDATA = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]                r_state, n_state;
    logic [ROWS_W-1:0]         r_rows_in_use;
    logic                      r_sat, n_sat;
    t_in_item                  r_item, n_item;
    logic [PTR_W-1:0]          r_j, n_j;
    logic [PTR_W-1:0]          r_end, n_end;
    logic [ROWS_W-1:0]         r_cnt, n_cnt;
    logic [ROW_W-1:0]          r_row, n_row;
    logic signed [WEIGHT_W-1:0] r_w, n_w;
    logic signed [SCORE_W-1:0] r_res, n_res;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;

    logic [ROWS_W-1:0]  w_rows_act;
    logic               w_in_xfer;
    logic [PTR_W-1:0]   w_j_next;
    logic [PTR_W-1:0]   w_end_cap;
    logic [ROW_W-1:0]   w_nz_row;
    logic [WEIGHT_W-1:0] w_nz_weight;
    logic signed [SCORE_W:0] w_sum;
    logic               w_ovf;
    logic [ROW_W:0]     w_col_next;

    logic                 col_we, col_re;
    logic [COL_AW-1:0]    col_waddr, col_raddr;
    logic [PTR_W-1:0]     col_wdata, col_rdata;
    logic                 nz_we, nz_re;
    logic [NZ_AW-1:0]     nz_waddr, nz_raddr;
    logic [NZ_W-1:0]      nz_wdata, nz_rdata;
    logic                 sc_we, sc_re;
    logic [ROW_AW-1:0]    sc_waddr, sc_raddr;
    logic [SCORE_W-1:0]   sc_wdata, sc_rdata;

    scsa_ram #(.WIDTH(PTR_W), .DEPTH(COL_DEPTH)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_re    (col_re),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    scsa_ram #(.WIDTH(NZ_W), .DEPTH(MAX_NONZEROS)) u_nz_ram (
        .i_clk   (i_clk),
        .i_we    (nz_we),
        .i_waddr (nz_waddr),
        .i_wdata (nz_wdata),
        .i_re    (nz_re),
        .i_raddr (nz_raddr),
        .o_rdata (nz_rdata)
    );

    scsa_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_ROWS)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_re    (sc_re),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    assign w_rows_act  = (32'(r_rows_in_use) < 32'(MAX_ROWS)) ? r_rows_in_use
                                                               : ROWS_W'(MAX_ROWS);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_j_next    = r_j + PTR_W'(1);
    assign w_end_cap   = (32'(col_rdata) > 32'(MAX_NONZEROS)) ? PTR_W'(MAX_NONZEROS)
                                                              : col_rdata;
    assign w_nz_row    = nz_rdata[NZ_W-1:WEIGHT_W];
    assign w_nz_weight = nz_rdata[WEIGHT_W-1:0];
    assign w_sum       = {sc_rdata[SCORE_W-1], sc_rdata}
                       + {{(SCORE_W+1-WEIGHT_W){r_w[WEIGHT_W-1]}}, r_w};
    assign w_ovf       = w_sum[SCORE_W] != w_sum[SCORE_W-1];
    assign w_col_next  = {1'b0, r_item.word_column} + (ROW_W+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_sat       = r_sat;
        n_item      = r_item;
        n_j         = r_j;
        n_end       = r_end;
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_w         = r_w;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        col_we    = 1'b0;
        col_waddr = COL_AW'(r_item.pointer_slot);
        col_wdata = r_item.pointer_value;
        col_re    = 1'b0;
        col_raddr = COL_AW'(r_item.word_column);
        nz_we     = 1'b0;
        nz_waddr  = NZ_AW'(r_item.entry_slot);
        nz_wdata  = {r_item.entry_row, r_item.entry_weight};
        nz_re     = 1'b0;
        nz_raddr  = NZ_AW'(r_j);
        sc_we     = 1'b0;
        sc_waddr  = ROW_AW'(r_cnt);
        sc_wdata  = '0;
        sc_re     = 1'b0;
        sc_raddr  = ROW_AW'(r_item.read_row);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_item  = i_in_data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res   = '0;
                n_state = ST_DONE;
                unique case (r_item.kind)
                    KIND_LOAD_PTR: begin
                        col_we = 32'(r_item.pointer_slot) <= 32'(MAX_COLUMNS);
                    end
                    KIND_LOAD_NZ: begin
                        nz_we = 32'(r_item.entry_slot) < 32'(MAX_NONZEROS);
                    end
                    KIND_ADD_COL: begin
                        n_state = ST_COL;
                        if (r_item.first_word) begin
                            n_sat = 1'b0;
                            n_cnt = '0;
                            if (w_rows_act != '0) begin
                                n_state = ST_CLR;
                            end
                        end
                    end
                    KIND_READ: begin
                        if ({1'b0, r_item.read_row} < w_rows_act) begin
                            sc_re   = 1'b1;
                            n_state = ST_RDATA;
                        end
                    end
                endcase
            end
            ST_CLR: begin
                sc_we = 1'b1;
                n_cnt = r_cnt + ROWS_W'(1);
                if (n_cnt == w_rows_act) begin
                    n_state = ST_COL;
                end
            end
            ST_COL: begin
                if (32'(r_item.word_column) < 32'(MAX_COLUMNS)) begin
                    col_re  = 1'b1;
                    n_state = ST_PTR0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PTR0: begin
                n_j       = col_rdata;
                col_re    = 1'b1;
                col_raddr = COL_AW'(w_col_next);
                n_state   = ST_PTR1;
            end
            ST_PTR1: begin
                n_end = w_end_cap;
                if (w_end_cap > r_j) begin
                    nz_re   = 1'b1;
                    n_state = ST_SCRD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCRD: begin
                n_row = w_nz_row;
                n_w   = w_nz_weight;
                if ({1'b0, w_nz_row} < w_rows_act) begin
                    sc_re    = 1'b1;
                    sc_raddr = ROW_AW'(w_nz_row);
                    n_state  = ST_ACC;
                end else begin
                    n_j = w_j_next;
                    if (w_j_next < r_end) begin
                        nz_re    = 1'b1;
                        nz_raddr = NZ_AW'(w_j_next);
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ACC: begin
                sc_we    = 1'b1;
                sc_waddr = ROW_AW'(r_row);
                if (w_ovf) begin
                    sc_wdata = w_sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
                    n_sat    = 1'b1;
                end else begin
                    sc_wdata = w_sum[SCORE_W-1:0];
                end
                n_j = w_j_next;
                if (w_j_next < r_end) begin
                    nz_re    = 1'b1;
                    nz_raddr = NZ_AW'(w_j_next);
                    n_state  = ST_SCRD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RDATA: begin
                n_res   = sc_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.score       = r_res;
                    n_out.score_valid = r_item.kind == KIND_READ;
                    n_out.saturated   = r_sat;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sat         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_rows_in_use <= ROWS_RESET;
        end else begin
            r_state     <= n_state;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_rows_in_use <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_j    <= n_j;
        r_end  <= n_end;
        r_cnt  <= n_cnt;
        r_row  <= n_row;
        r_w    <= n_w;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### src/scsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module scsa_checker
    import scsa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_cfg_wr_en,
    input wire logic [ROWS_W-1:0] i_cfg_wr_data,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire t_in_item          i_in_data,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire t_out_item         o_out_data
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && !o_in_stall;

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("input taken while an item is in work");

    a_score_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.score_valid |-> o_out_data.score == '0)
        else $error("nonzero score on a non-read result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind sparse_column_score_accumulator_unit scsa_checker u_scsa_checker (.*);

`default_nettype wire

### test/sparse_column_score_accumulator_unit_tb.sv
`timescale 1ns / 1ps

module sparse_column_score_accumulator_unit_tb;
    import scsa_pkg::*;

    localparam longint SCORE_TOP    = 64'sd549755813887;
    localparam longint SCORE_BOTTOM = -64'sd549755813888;
    localparam int     PHASE_ITEMS  = 267;
    localparam int     HOLD_CYCLES  = 600;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [ROWS_W-1:0] i_cfg_wr_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;

    sparse_column_score_accumulator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

    // score engine mirror, updated on every input transfer
    logic [PTR_W-1:0]           col_start_mem [0:SCSA_MAX_COLUMNS];
    logic [ROW_W-1:0]           nz_row_mem    [0:SCSA_MAX_NONZEROS-1];
    logic signed [WEIGHT_W-1:0] nz_weight_mem [0:SCSA_MAX_NONZEROS-1];
    logic signed [SCORE_W-1:0]  score_mem     [0:SCSA_MAX_ROWS-1];
    bit                         sat_seen = 1'b0;
    int                         model_rows = SCSA_MAX_ROWS;

    // stimulus-side view of which table entries and scores hold defined data
    int  plan_ptr       [0:SCSA_MAX_COLUMNS];
    bit  plan_ptr_set   [0:SCSA_MAX_COLUMNS];
    int  plan_nz_row    [0:SCSA_MAX_NONZEROS-1];
    bit  plan_nz_set    [0:SCSA_MAX_NONZEROS-1];
    bit  plan_row_live  [0:SCSA_MAX_ROWS-1];
    int  plan_rows = SCSA_MAX_ROWS;
    int  hot_rows [4];
    int  known_cols [$];

    t_in_item  pending_items [$];
    t_out_item score_expect [$];

    bit in_xfer = 1'b0;
    bit steady = 1'b0;
    bit choke_go = 1'b0;
    bit choke_begun = 1'b0;
    int choke_left = 0;

    int items_planned = 0;
    int items_taken = 0;
    int results_seen = 0;
    int reads_taken = 0;
    int adds_taken = 0;
    int sat_results = 0;
    int mismatches = 0;
    int settings_used = 0;

    function automatic t_out_item accumulate_item(input t_in_item it);
        t_out_item res;
        int        live, lo, hi, j, r;
        longint    total;
        res = '0;
        live = (model_rows < SCSA_MAX_ROWS) ? model_rows : SCSA_MAX_ROWS;
        case (it.kind)
            KIND_LOAD_PTR: begin
                if (it.pointer_slot <= SCSA_MAX_COLUMNS)
                    col_start_mem[it.pointer_slot] = it.pointer_value;
            end
            KIND_LOAD_NZ: begin
                nz_row_mem[it.entry_slot] = it.entry_row;
                nz_weight_mem[it.entry_slot] = it.entry_weight;
            end
            KIND_ADD_COL: begin
                if (it.first_word) begin
                    for (r = 0; r < live; r++)
                        score_mem[r] = '0;
                    sat_seen = 1'b0;
                end
                lo = col_start_mem[it.word_column];
                hi = col_start_mem[int'(it.word_column) + 1];
                if (hi > SCSA_MAX_NONZEROS)
                    hi = SCSA_MAX_NONZEROS;
                for (j = lo; j < hi; j++) begin
                    r = nz_row_mem[j];
                    if (r < live) begin
                        total = longint'(score_mem[r]) + longint'(nz_weight_mem[j]);
                        if (total > SCORE_TOP) begin
                            total = SCORE_TOP;
                            sat_seen = 1'b1;
                        end else if (total < SCORE_BOTTOM) begin
                            total = SCORE_BOTTOM;
                            sat_seen = 1'b1;
                        end
                        score_mem[r] = total[SCORE_W-1:0];
                    end
                end
            end
            default: begin
                res.score_valid = 1'b1;
                if (it.read_row < live)
                    res.score = score_mem[it.read_row];
            end
        endcase
        res.saturated = sat_seen;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("tb: mismatch at result %0d: %s is %0d, expected %0d",
                 results_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        in_xfer = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_out_data.saturated)
                sat_results++;
            if (score_expect.size() == 0) begin
                flag_mismatch("result with nothing pending, score", o_out_data.score, 0);
            end else begin
                want = score_expect.pop_front();
                if (o_out_data.score !== want.score)
                    flag_mismatch("score", o_out_data.score, want.score);
                if (o_out_data.score_valid !== want.score_valid)
                    flag_mismatch("score_valid", o_out_data.score_valid, want.score_valid);
                if (o_out_data.saturated !== want.saturated)
                    flag_mismatch("saturated", o_out_data.saturated, want.saturated);
            end
        end
        if (in_xfer) begin
            items_taken++;
            if (i_in_data.kind == KIND_READ)
                reads_taken++;
            if (i_in_data.kind == KIND_ADD_COL)
                adds_taken++;
            score_expect.push_back(accumulate_item(i_in_data));
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_xfer)) begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99, 0) >= 26)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (choke_go && !choke_begun) begin
            choke_begun = 1'b1;
            choke_left = HOLD_CYCLES;
        end
        if (choke_left > 0) begin
            choke_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(99, 0) < 26);
        end
    end

    function automatic t_in_item random_fields();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return t_in_item'(bits[$bits(t_in_item)-1:0]);
    endfunction

    function automatic t_in_item make_ptr(input int slot, input int value);
        t_in_item it;
        it = random_fields();
        it.kind = KIND_LOAD_PTR;
        it.pointer_slot = 13'(slot);
        it.pointer_value = PTR_W'(value);
        return it;
    endfunction

    function automatic t_in_item make_nz(input int slot, input int row,
                                         input logic [WEIGHT_W-1:0] weight);
        t_in_item it;
        it = random_fields();
        it.kind = KIND_LOAD_NZ;
        it.entry_slot = 16'(slot);
        it.entry_row = ROW_W'(row);
        it.entry_weight = weight;
        return it;
    endfunction

    function automatic t_in_item make_add(input int col, input bit first);
        t_in_item it;
        it = random_fields();
        it.kind = KIND_ADD_COL;
        it.word_column = ROW_W'(col);
        it.first_word = first;
        return it;
    endfunction

    function automatic t_in_item make_read(input int row);
        t_in_item it;
        it = random_fields();
        it.kind = KIND_READ;
        it.read_row = ROW_W'(row);
        return it;
    endfunction

    function automatic bit column_safe(input int col, input bit first);
        int lo, hi, j;
        if (!plan_ptr_set[col] || !plan_ptr_set[col + 1])
            return 1'b0;
        lo = plan_ptr[col];
        hi = plan_ptr[col + 1];
        if (hi > SCSA_MAX_NONZEROS)
            hi = SCSA_MAX_NONZEROS;
        for (j = lo; j < hi; j++) begin
            if (!plan_nz_set[j])
                return 1'b0;
            if (!first && plan_nz_row[j] < plan_rows && !plan_row_live[plan_nz_row[j]])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_row();
        if ($urandom_range(9, 0) < 6)
            return hot_rows[$urandom_range(3, 0)];
        return $urandom_range(4095, 0);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(6, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(1 << 20, 0) - (1 << 19);
        endcase
    endfunction

    task automatic queue_item(input t_in_item it);
        int r;
        case (it.kind)
            KIND_LOAD_PTR: begin
                if (it.pointer_slot <= SCSA_MAX_COLUMNS) begin
                    plan_ptr[it.pointer_slot] = it.pointer_value;
                    plan_ptr_set[it.pointer_slot] = 1'b1;
                end
            end
            KIND_LOAD_NZ: begin
                plan_nz_row[it.entry_slot] = it.entry_row;
                plan_nz_set[it.entry_slot] = 1'b1;
            end
            KIND_ADD_COL: begin
                if (it.first_word)
                    for (r = 0; r < plan_rows; r++)
                        plan_row_live[r] = 1'b1;
            end
            default: ;
        endcase
        pending_items.push_back(it);
        items_planned++;
    endtask

    task automatic queue_read(input int row);
        if (row < plan_rows && !plan_row_live[row]) begin
            if (plan_rows >= SCSA_MAX_ROWS) begin
                queue_item(make_ptr($urandom_range(8191, SCSA_MAX_COLUMNS + 1), $urandom));
                return;
            end
            row = $urandom_range(SCSA_MAX_ROWS - 1, plan_rows);
        end
        queue_item(make_read(row));
    endtask

    task automatic queue_add(input int col, input bit first);
        if (column_safe(col, first))
            queue_item(make_add(col, first));
        else
            queue_read($urandom_range(4095, 0));
    endtask

    task automatic build_query();
        int c, lo, hi, style, j, k;
        c = $urandom_range(SCSA_MAX_COLUMNS - 1, 0);
        lo = $urandom_range(65475, 40);
        style = $urandom_range(99, 0);
        if (style < 70)
            hi = lo + $urandom_range(12, 1);
        else if (style < 85)
            hi = lo;
        else if (style < 95)
            hi = lo + $urandom_range(60, 13);
        else
            hi = lo - $urandom_range(40, 1);
        for (k = 0; k < 4; k++)
            hot_rows[k] = $urandom_range(plan_rows - 1, 0);
        for (j = lo; j < hi; j++)
            queue_item(make_nz(j, pick_row(), pick_weight()));
        if ($urandom_range(1, 0)) begin
            queue_item(make_ptr(c, lo));
            queue_item(make_ptr(c + 1, hi));
        end else begin
            queue_item(make_ptr(c + 1, hi));
            queue_item(make_ptr(c, lo));
        end
        queue_add(c, 1'b1);
        known_cols.push_back(c);
        repeat ($urandom_range(4, 0)) begin
            if ($urandom_range(2, 0) == 0)
                queue_add(known_cols[$urandom_range(known_cols.size() - 1, 0)],
                          $urandom_range(9, 0) == 0);
            else
                queue_add(c, 1'b0);
        end
        repeat ($urandom_range(5, 1)) begin
            if ($urandom_range(3, 0) == 0)
                queue_read($urandom_range(4095, 0));
            else
                queue_read(hot_rows[$urandom_range(3, 0)]);
        end
    endtask

    // eighteen adds of a sixteen-entry column of extreme weights on one row
    // drive the score past the bound in either direction
    task automatic build_saturation();
        int c, lo, row, j;
        logic [WEIGHT_W-1:0] w;
        c = $urandom_range(SCSA_MAX_COLUMNS - 1, 0);
        lo = $urandom_range(65519, 0);
        row = $urandom_range(plan_rows - 1, 0);
        w = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        for (j = 0; j < 16; j++)
            queue_item(make_nz(lo + j, row, w));
        queue_item(make_ptr(c, lo));
        queue_item(make_ptr(c + 1, lo + 16));
        queue_add(c, 1'b1);
        repeat (17) queue_add(c, 1'b0);
        queue_read(row);
        queue_add(c, 1'b1);
        queue_read(row);
    endtask

    task automatic queue_noise();
        t_in_item it;
        repeat ($urandom_range(6, 1)) begin
            it = random_fields();
            case (it.kind)
                KIND_LOAD_PTR, KIND_LOAD_NZ: queue_item(it);
                KIND_ADD_COL: begin
                    if (column_safe(it.word_column, it.first_word))
                        queue_item(it);
                    else
                        queue_read(it.read_row);
                end
                default: queue_read(it.read_row);
            endcase
        end
    endtask

    task automatic run_random_phase(input int target);
        int stop_at, pick;
        stop_at = items_planned + target;
        while (items_planned < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 6)
                build_saturation();
            else if (pick < 35)
                queue_noise();
            else
                build_query();
        end
    endtask

    task automatic settle_block();
        int guard;
        guard = 0;
        while ((items_taken < items_planned || score_expect.size() != 0)
               && guard < 400000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_rows(input int value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= ROWS_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_rows = value;
        plan_rows = (value < SCSA_MAX_ROWS) ? value : SCSA_MAX_ROWS;
        settings_used++;
    endtask

    initial begin
        int rows_list [6];
        int p;
        rows_list = '{1, 4096, 150, 8191, 12, 2000};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(make_ptr(0, 0));
        queue_item(make_ptr(1, 3));
        queue_item(make_nz(0, 0, 32'h7FFF_FFFF));
        queue_item(make_nz(1, 4095, 32'h8000_0000));
        queue_item(make_nz(2, 6, 32'h0000_0001));
        queue_item(make_add(0, 1'b1));
        queue_item(make_read(0));
        queue_item(make_read(4095));
        queue_item(make_ptr(8191, 131071));
        queue_item(make_ptr(SCSA_MAX_COLUMNS + 1, 5));
        queue_item(make_read(6));
        settle_block();

        write_rows(5);
        queue_item(make_ptr(4094, 65534));
        queue_item(make_ptr(4095, 131071));
        queue_item(make_ptr(4096, 65530));
        queue_item(make_nz(65534, 4, 32'h0001_0000));
        queue_item(make_nz(65535, 5, 32'hFFFF_0000));
        queue_item(make_add(4094, 1'b0));
        queue_item(make_add(4095, 1'b0));
        queue_item(make_read(4));
        queue_item(make_read(5));
        queue_item(make_add(0, 1'b1));
        queue_item(make_read(0));
        queue_item(make_read(4095));
        queue_item(make_add(4095, 1'b1));
        queue_item(make_read(0));
        settle_block();

        for (p = 0; p < 6; p++) begin
            write_rows(rows_list[p]);
            steady = (p == 3);
            choke_go = (p == 2);
            run_random_phase(PHASE_ITEMS);
            settle_block();
        end
        steady = 1'b0;

        if (score_expect.size() != 0)
            flag_mismatch("results never delivered", score_expect.size(), 0);
        $display("tb: %0d input transfers, %0d results checked, %0d mismatches",
                 items_taken, results_seen, mismatches);
        $display("tb: %0d score reads, %0d column adds, %0d results flagged saturated, %0d row settings",
                 reads_taken, adds_taken, sat_results, settings_used);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
src/scsa_pkg.sv
src/scsa_ram.sv
src/sparse_column_score_accumulator_unit.sv
src/scsa_checker.sv
test/sparse_column_score_accumulator_unit_tb.sv
